>>> rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// shared types and constants of the can bit timing calculator
// ----------------------------------------------------------------------------
package cbt_pkg;

    // field widths
    localparam int CLK_W   = 17;
    localparam int RATE_W  = 20;
    localparam int SP_W    = 14;
    localparam int SRC_W   = 2;
    localparam int TQ_W    = 5;
    localparam int SEG_W   = 3;
    localparam int SJW_W   = 2;
    localparam int PF_W    = 8;

    // divider operands: clock in hz fits 27 bits, divisor holds the bit rate
    localparam int DVD_W   = 27;
    localparam int DVS_W   = 20;
    localparam int PROD_W  = TQ_W + SP_W;

    // split point by reciprocal: (x * SP_RECIP) >> SP_RECIP_SH equals x / 10000
    // for every quanta times sample point product
    localparam int RECIP_W     = 19;
    localparam int SPLIT_W     = PROD_W + RECIP_W;
    localparam int SP_RECIP    = 429497;
    localparam int SP_RECIP_SH = 32;

    localparam int CLK_SCALE = 1000;
    localparam int SP_MIN    = 100;
    localparam int SP_FULL   = 10000;
    localparam int TQ_MIN    = 8;
    localparam int TQ_LIMIT  = 20;
    localparam int SJW_MAX   = 3;
    localparam int PF_MAX    = 255;
    localparam int SRC_MAX   = 1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_SRC = 3'd1,
        ST_SP_LOW  = 3'd2,
        ST_NO_PRE  = 3'd3,
        ST_SEG     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SEL_TICKS = 2'd0,
        SEL_QUOT  = 2'd1
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_ticks;
        logic     search_step;
        logic     cap_q;
        logic     cap_prod;
        logic     cap_s;
        logic     out_load;
        t_status  out_code;
    } t_cmd;

    typedef struct packed {
        logic src_bad;
        logic sp_low;
        logic rate_zero;
        logic div_done;
        logic div_busy;
        logic hit;
        logic last_p;
        logic seg_bad;
    } t_stat;

endpackage

>>> rtl/can_bit_timing_calculator.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calculator
// turns a clock rate, bit rate and sample point into can bit timing fields
// ----------------------------------------------------------------------------
// One request is worked on at a time. A rejected clock source, sample point
// or zero bit rate ends it after the checks. Otherwise two divisions run
// through one shared restoring divider at one quotient bit per cycle, the
// search tries one prescaler per cycle, up to MAX_PRESCALER of them, and the
// split point comes from a reciprocal multiply. A result waits to be loaded
// while a stalled one holds the output register. A finished result waits in
// the output register while the next transaction is taken in.
module can_bit_timing_calculator
    import cbt_pkg::*;
#(
    parameter int MAX_PRESCALER = 255
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CLK_W-1:0]  i_clock_khz,
    input  logic [RATE_W-1:0] i_bit_rate,
    input  logic [SP_W-1:0]   i_sample_point,
    input  logic [SRC_W-1:0]  i_clock_source,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [PF_W-1:0]   o_prescaler_field,
    output logic [TQ_W-1:0]   o_quanta_per_bit,
    output logic [SEG_W-1:0]  o_prop_segment,
    output logic [SEG_W-1:0]  o_phase_one_field,
    output logic [SEG_W-1:0]  o_phase_two_field,
    output logic [SJW_W-1:0]  o_jump_width,
    output logic              o_clock_select
);

    t_cmd  cmd;
    t_stat stat;

    cbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cbt_dp #(
        .MAX_PRESCALER (MAX_PRESCALER)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_clock_khz       (i_clock_khz),
        .i_bit_rate        (i_bit_rate),
        .i_sample_point    (i_sample_point),
        .i_clock_source    (i_clock_source),
        .o_status          (o_status),
        .o_prescaler_field (o_prescaler_field),
        .o_quanta_per_bit  (o_quanta_per_bit),
        .o_prop_segment    (o_prop_segment),
        .o_phase_one_field (o_phase_one_field),
        .o_phase_two_field (o_phase_two_field),
        .o_jump_width      (o_jump_width),
        .o_clock_select    (o_clock_select)
    );

endmodule

>>> rtl/cbt_div.sv
// ----------------------------------------------------------------------------
// cbt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cbt_div
    import cbt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? DVS_W'(trial - {1'b0, r_den}) : trial[DVS_W-1:0];
        n_quo = {r_quo[DVD_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> r_busy || r_done)
        else $error("division stopped without done");

endmodule

>>> rtl/cbt_dp.sv
// ----------------------------------------------------------------------------
// cbt_dp
// datapath: request registers, shared divider, prescaler search, segment split
// ----------------------------------------------------------------------------
module cbt_dp
    import cbt_pkg::*;
#(
    parameter int MAX_PRESCALER = 255
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [CLK_W-1:0]  i_clock_khz,
    input  logic [RATE_W-1:0] i_bit_rate,
    input  logic [SP_W-1:0]   i_sample_point,
    input  logic [SRC_W-1:0]  i_clock_source,
    output logic [2:0]        o_status,
    output logic [PF_W-1:0]   o_prescaler_field,
    output logic [TQ_W-1:0]   o_quanta_per_bit,
    output logic [SEG_W-1:0]  o_prop_segment,
    output logic [SEG_W-1:0]  o_phase_one_field,
    output logic [SEG_W-1:0]  o_phase_two_field,
    output logic [SJW_W-1:0]  o_jump_width,
    output logic              o_clock_select
);

    localparam int P_W   = $clog2(MAX_PRESCALER + 1);
    localparam int LIM_W = P_W + 5;

    logic [CLK_W-1:0]  r_clk;
    logic [RATE_W-1:0] r_rate;
    logic [SP_W-1:0]   r_sp;
    logic [SRC_W-1:0]  r_src;
    logic [DVD_W-1:0]  r_ticks;
    logic [P_W-1:0]    r_p;
    logic [LIM_W-1:0]  r_lo;
    logic [LIM_W-1:0]  r_hi;
    logic [TQ_W-1:0]   r_tq;
    logic [PROD_W-1:0] r_prod;
    logic [TQ_W-1:0]   r_s;

    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic [DVD_W-1:0]  quo;
    logic              div_done;
    logic              div_busy;

    logic [SPLIT_W-1:0] split_prod;
    logic [P_W-1:0]    p_m1;
    logic signed [6:0] sv, half, prop, ph1, ph2, ph2m1;
    logic              seg_bad;

    always_comb begin
        unique case (i_cmd.div_sel)
            SEL_TICKS: begin
                dvd = DVD_W'(r_clk) * DVD_W'(CLK_SCALE);
                dvs = r_rate;
            end
            SEL_QUOT: begin
                dvd = r_ticks;
                dvs = DVS_W'(r_p);
            end
            default: begin
                dvd = '0;
                dvs = DVS_W'(1);
            end
        endcase
    end

    cbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // quanta times sample point over 10000
    assign split_prod = SPLIT_W'(r_prod) * SPLIT_W'(SP_RECIP);

    // split point: s quanta up to the sample point, sync quantum included
    always_comb begin
        p_m1  = r_p - 1'b1;
        sv    = 7'(r_s);
        half  = (sv - (r_s[0] ? 7'sd1 : 7'sd2)) >>> 1;
        prop  = r_s[0] ? half : half + 7'sd1;
        ph1   = half - 7'sd2;
        ph2   = 7'(r_tq) - sv;
        ph2m1 = ph2 - 7'sd1;
        seg_bad = (32'(p_m1) > 32'(PF_MAX)) ||
                  prop < 7'sd0 || prop > 7'sd7 || ph1 < 7'sd0 || ph1 > 7'sd7 ||
                  ph2 < 7'sd1 || ph2 > 7'sd8;
    end

    always_comb begin
        o_stat.src_bad   = (r_src > SRC_W'(SRC_MAX));
        o_stat.sp_low    = (r_sp < SP_W'(SP_MIN));
        o_stat.rate_zero = (r_rate == '0);
        o_stat.div_done  = div_done;
        o_stat.div_busy  = div_busy;
        // ticks/p lies in 8..19 exactly when 8p <= ticks < 20p
        o_stat.hit       = (r_ticks >= DVD_W'(r_lo)) && (r_ticks < DVD_W'(r_hi));
        o_stat.last_p    = (r_p == P_W'(MAX_PRESCALER));
        o_stat.seg_bad   = seg_bad;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clk  <= i_clock_khz;
            r_rate <= i_bit_rate;
            r_sp   <= i_sample_point;
            r_src  <= i_clock_source;
        end
        if (i_cmd.cap_ticks) begin
            r_ticks <= quo;
            r_p     <= P_W'(1);
            r_lo    <= LIM_W'(TQ_MIN);
            r_hi    <= LIM_W'(TQ_LIMIT);
        end else if (i_cmd.search_step) begin
            r_p  <= r_p + 1'b1;
            r_lo <= r_lo + LIM_W'(TQ_MIN);
            r_hi <= r_hi + LIM_W'(TQ_LIMIT);
        end
        if (i_cmd.cap_q) begin
            r_tq <= quo[TQ_W-1:0];
        end
        if (i_cmd.cap_prod) begin
            r_prod <= PROD_W'(r_tq) * PROD_W'(r_sp);
        end
        if (i_cmd.cap_s) begin
            r_s <= split_prod[SP_RECIP_SH +: TQ_W];
        end
    end

    // result register, every field but status is zero on error
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= i_cmd.out_code;
            if (i_cmd.out_code == ST_OK) begin
                o_prescaler_field <= p_m1[PF_W-1:0];
                o_quanta_per_bit  <= r_tq;
                o_prop_segment    <= prop[SEG_W-1:0];
                o_phase_one_field <= ph1[SEG_W-1:0];
                o_phase_two_field <= ph2m1[SEG_W-1:0];
                o_jump_width      <= (ph2m1 > 7'(SJW_MAX)) ? SJW_W'(SJW_MAX)
                                                          : ph2m1[SJW_W-1:0];
                o_clock_select    <= r_src[0];
            end else begin
                o_prescaler_field <= '0;
                o_quanta_per_bit  <= '0;
                o_prop_segment    <= '0;
                o_phase_one_field <= '0;
                o_phase_two_field <= '0;
                o_jump_width      <= '0;
                o_clock_select    <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/cbt_ctrl.sv
// ----------------------------------------------------------------------------
// cbt_ctrl
// sequencer for request checks, divisions, prescaler search and result hand-off
// ----------------------------------------------------------------------------
module cbt_ctrl
    import cbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TICKS,
        S_SEARCH,
        S_QUOT,
        S_MUL,
        S_SPLIT,
        S_SEG,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;
    logic    in_acc;
    logic    out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.div_sel  = SEL_TICKS;
        o_cmd.out_code = r_code;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.src_bad) begin
                    n_code  = ST_BAD_SRC;
                    n_state = S_FINISH;
                end else if (i_stat.sp_low) begin
                    n_code  = ST_SP_LOW;
                    n_state = S_FINISH;
                end else if (i_stat.rate_zero) begin
                    n_code  = ST_NO_PRE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_TICKS;
                end
            end
            S_TICKS: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_ticks = 1'b1;
                    n_state         = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.div_sel = SEL_QUOT;
                priority if (i_stat.hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_QUOT;
                end else if (i_stat.last_p) begin
                    n_code  = ST_NO_PRE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_QUOT: begin
                o_cmd.div_sel = SEL_QUOT;
                if (i_stat.div_done) begin
                    o_cmd.cap_q = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.cap_prod = 1'b1;
                n_state        = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.cap_s = 1'b1;
                n_state     = S_SEG;
            end
            S_SEG: begin
                n_code  = i_stat.seg_bad ? ST_SEG : ST_OK;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_CHECK)
        else $error("accepted transaction did not start the checks");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while held");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("division started while divider busy");

endmodule

>>> tb/can_bit_timing_calculator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_bit_timing_calculator_tb
// self-checking testbench of the can bit timing calculator
// ----------------------------------------------------------------------------
// Drives timing requests through the input channel and predicts every result
// with an independent model of the prescaler search and segment split. Each
// result transaction is compared field by field with the oldest prediction.
// Directed requests cover every status code and the field extremes; a long
// receiver hold-off fills the block; random requests are mostly well-formed
// rates with random content, the rest full-width noise. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_tb;
    import cbt_pkg::*;

    localparam int     PRESC_LIMIT  = 255;
    localparam int     RESET_CYCLES = 7;
    localparam int     DRAIN_CYCLES = 400;
    localparam int     HOLD_CYCLES  = 2500;
    localparam int     RANDOM_ITEMS = 680;
    localparam longint TIMEOUT_NS   = 64'd24_000_000;

    typedef struct packed {
        t_status           status;
        logic [PF_W-1:0]   prescaler_field;
        logic [TQ_W-1:0]   quanta_per_bit;
        logic [SEG_W-1:0]  prop_segment;
        logic [SEG_W-1:0]  phase_one_field;
        logic [SEG_W-1:0]  phase_two_field;
        logic [SJW_W-1:0]  jump_width;
        logic              clock_select;
    } t_timing;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [CLK_W-1:0]  i_clock_khz    = '0;
    logic [RATE_W-1:0] i_bit_rate     = '0;
    logic [SP_W-1:0]   i_sample_point = '0;
    logic [SRC_W-1:0]  i_clock_source = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [2:0]        o_status;
    logic [PF_W-1:0]   o_prescaler_field;
    logic [TQ_W-1:0]   o_quanta_per_bit;
    logic [SEG_W-1:0]  o_prop_segment;
    logic [SEG_W-1:0]  o_phase_one_field;
    logic [SEG_W-1:0]  o_phase_two_field;
    logic [SJW_W-1:0]  o_jump_width;
    logic              o_clock_select;

    t_timing expected_timing[$];
    int      mismatch_count = 0;
    int      burst_left     = 0;
    bit      hold_req       = 1'b0;
    bit      hold_active    = 1'b0;
    int      hold_left      = 0;

    can_bit_timing_calculator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_clock_khz       (i_clock_khz),
        .i_bit_rate        (i_bit_rate),
        .i_sample_point    (i_sample_point),
        .i_clock_source    (i_clock_source),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_prescaler_field (o_prescaler_field),
        .o_quanta_per_bit  (o_quanta_per_bit),
        .o_prop_segment    (o_prop_segment),
        .o_phase_one_field (o_phase_one_field),
        .o_phase_two_field (o_phase_two_field),
        .o_jump_width      (o_jump_width),
        .o_clock_select    (o_clock_select)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** can_bit_timing_calculator: FAILED **");
        $finish;
    end

    function automatic t_timing predict_timing(input logic [CLK_W-1:0] clk_khz,
                                               input logic [RATE_W-1:0] rate,
                                               input logic [SP_W-1:0] sp,
                                               input logic [SRC_W-1:0] src);
        t_timing           r;
        longint unsigned   ticks;
        longint unsigned   q;
        int                tq;
        int                presc;
        int                s;
        int                half;
        int                prop;
        int                ph1;
        int                ph2;
        bit                found;
        r     = '0;
        tq    = 0;
        presc = 0;
        found = 1'b0;
        if (src > SRC_MAX) begin
            r.status = ST_BAD_SRC;
            return r;
        end
        if (sp < SP_MIN) begin
            r.status = ST_SP_LOW;
            return r;
        end
        if (rate != 0) begin
            ticks = (longint'(clk_khz) * CLK_SCALE) / longint'(rate);
            for (int p = 1; p <= PRESC_LIMIT; p++) begin
                q = ticks / p;
                if (!found && q >= TQ_MIN && q < TQ_LIMIT) begin
                    found = 1'b1;
                    tq    = int'(q);
                    presc = p;
                end
            end
        end
        if (!found) begin
            r.status = ST_NO_PRE;
            return r;
        end
        // quanta up to the sample point, sync quantum included
        s = (tq * int'(sp)) / SP_FULL;
        if (s % 2 == 0) begin
            half = (s - 2) / 2;
            prop = half + 1;
        end else begin
            half = (s - 1) / 2;
            prop = half;
        end
        ph1 = half - 2;
        ph2 = tq - s;
        if (presc - 1 > PF_MAX || prop < 0 || prop > 7 || ph1 < 0 || ph1 > 7 ||
            ph2 < 1 || ph2 > 8) begin
            r.status = ST_SEG;
            return r;
        end
        r.status          = ST_OK;
        r.prescaler_field = PF_W'(presc - 1);
        r.quanta_per_bit  = TQ_W'(tq);
        r.prop_segment    = SEG_W'(prop);
        r.phase_one_field = SEG_W'(ph1);
        r.phase_two_field = SEG_W'(ph2 - 1);
        r.jump_width      = SJW_W'((ph2 - 1 > SJW_MAX) ? SJW_MAX : ph2 - 1);
        r.clock_select    = src[0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // result transactions
    always @(posedge i_clk) begin
        t_timing e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_timing.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatch_count++;
            end else begin
                e = expected_timing.pop_front();
                check_field("status", e.status, o_status);
                check_field("prescaler_field", e.prescaler_field, o_prescaler_field);
                check_field("quanta_per_bit", e.quanta_per_bit, o_quanta_per_bit);
                check_field("prop_segment", e.prop_segment, o_prop_segment);
                check_field("phase_one_field", e.phase_one_field, o_phase_one_field);
                check_field("phase_two_field", e.phase_two_field, o_phase_two_field);
                check_field("jump_width", e.jump_width, o_jump_width);
                check_field("clock_select", e.clock_select, o_clock_select);
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int run_left;
        int pct;
        run_left = 0;
        pct      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_CYCLES;
                hold_active = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                hold_active = 1'b0;
                if (run_left == 0) begin
                    run_left = $urandom_range(300, 20);
                    pct      = ($urandom_range(3) == 0) ? 0 : $urandom_range(80, 10);
                end
                run_left--;
                i_out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    // with valid still high
    task automatic send_request(input logic [CLK_W-1:0] clk_khz,
                                input logic [RATE_W-1:0] rate,
                                input logic [SP_W-1:0] sp,
                                input logic [SRC_W-1:0] src);
        t_timing e;
        e = predict_timing(clk_khz, rate, sp, src);
        i_in_valid     <= 1'b1;
        i_clock_khz    <= clk_khz;
        i_bit_rate     <= rate;
        i_sample_point <= sp;
        i_clock_source <= src;
        do @(posedge i_clk); while (o_in_stall);
        expected_timing.push_back(e);
        @(negedge i_clk);
    endtask

    task automatic send_item(input logic [CLK_W-1:0] clk_khz,
                             input logic [RATE_W-1:0] rate,
                             input logic [SP_W-1:0] sp,
                             input logic [SRC_W-1:0] src);
        int gap;
        send_request(clk_khz, rate, sp, src);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(400, 40) : $urandom_range(30, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(25, 8) : $urandom_range(6);
        end
    endtask

    task automatic test_status_codes();
        send_item(17'd8000, 20'd500000, 14'd8750, 2'd2);     // bad clock source
        send_item(17'd8000, 20'd500000, 14'd0, 2'd3);        // source checked before sample point
        send_item(17'd8000, 20'd500000, 14'd0, 2'd0);        // sample point zero
        send_item(17'd8000, 20'd500000, 14'd99, 2'd1);       // just below minimum
        send_item(17'd8000, 20'd0, 14'd8750, 2'd0);          // zero bit rate
        send_item(17'd1, 20'd1000000, 14'd8750, 2'd0);       // too few ticks
        send_item(17'h1FFFF, 20'd1, 14'd8750, 2'd0);         // too many ticks
        send_item(17'd5100, 20'd1000, 14'd8750, 2'd0);       // just past the last prescaler
        send_item(17'd8000, 20'd500000, 14'd10000, 2'd0);    // no phase 2 left
        send_item(17'd8000, 20'd500000, 14'd100, 2'd0);      // split point of zero
        send_item(17'd8000, 20'd1000000, 14'd5000, 2'd0);    // negative phase 1
        send_item(17'd19000, 20'd1000000, 14'd9500, 2'd0);   // prop above 7
        send_item(17'd19000, 20'd1000000, 14'd5000, 2'd0);   // phase 2 above 8
    endtask

    task automatic test_field_extremes();
        send_item(17'd8000, 20'd500000, 14'd8750, 2'd0);     // even split point
        send_item(17'd16000, 20'd1000000, 14'd8125, 2'd1);   // odd split point
        send_item(17'd8000, 20'd1000000, 14'd8750, 2'd0);    // fewest quanta, shortest phase 2
        send_item(17'd16000, 20'd1000000, 14'd6875, 2'd1);   // jump width capped
        send_item(17'd5090, 20'd1000, 14'd8000, 2'd0);       // last prescaler
        send_item(17'd80000, 20'd1000000, 14'd8750, 2'd1);
        send_item(17'h1FFFF, 20'hFFFFF, 14'd8000, 2'd0);
        send_item(17'h1FFFF, 20'hFFFFF, 14'h3FFF, 2'd1);     // sample point above full
        send_item(17'h1FFFF, 20'hFFFFF, 14'h3FFF, 2'd3);
    endtask

    // receiver holds off while requests keep coming, the block backs up
    task automatic test_backpressure();
        i_in_valid <= 1'b0;
        hold_req = 1'b1;
        @(negedge i_clk);
        wait (hold_active);
        for (int k = 0; k < 6; k++) begin
            send_request(17'd40000, 20'd250000, 14'(8000 + 100 * k), 2'(k % 2));
        end
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_random_requests();
        logic [CLK_W-1:0]  c;
        logic [RATE_W-1:0] r;
        logic [SP_W-1:0]   sp;
        logic [SRC_W-1:0]  src;
        longint            denom;
        longint            rate_l;
        int                tq;
        int                p;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(9) < 7) begin
                // well-formed: aim at a quanta count and prescaler
                c     = ($urandom_range(7) == 0) ? CLK_W'($urandom_range(131071, 1))
                                                 : CLK_W'($urandom_range(100000, 1000));
                tq    = $urandom_range(19, 8);
                p     = ($urandom_range(9) < 7) ? $urandom_range(16, 1) : $urandom_range(255, 1);
                denom = tq * p + $urandom_range(p - 1);
                rate_l = (longint'(c) * CLK_SCALE) / denom;
                if (rate_l < 1)
                    rate_l = 1;
                if (rate_l > 1048575)
                    rate_l = 1048575;
                r   = RATE_W'(rate_l);
                sp  = ($urandom_range(4) != 0) ? SP_W'($urandom_range(9500, 5000))
                                               : SP_W'($urandom_range(16383, 100));
                src = SRC_W'($urandom_range(1));
            end else begin
                c   = CLK_W'($urandom);
                r   = RATE_W'($urandom);
                sp  = SP_W'($urandom);
                src = SRC_W'($urandom);
            end
            send_item(c, r, sp, src);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_status_codes();
        test_field_extremes();
        test_backpressure();
        test_random_requests();
        i_in_valid <= 1'b0;
        while (expected_timing.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_timing.size() != 0) begin
            $error("%0d results never arrived", expected_timing.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("** can_bit_timing_calculator: PASSED **");
        end else begin
            $display("** can_bit_timing_calculator: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cbt_pkg.sv
rtl/cbt_div.sv
rtl/cbt_dp.sv
rtl/cbt_ctrl.sv
rtl/can_bit_timing_calculator.sv
tb/can_bit_timing_calculator_tb.sv
